// File: rtl/core/satp_pkg.sv
// Shared types, constants and helper functions of the socket address text parser.
package satp_pkg;

    localparam int MAX_TEXT_LEN_DEF = 64;

    localparam logic [7:0] CAP_RESET   = 8'd28;
    localparam logic [7:0] CAP_IP4_MIN = 8'd16;
    localparam logic [7:0] CAP_IP6_MIN = 8'd28;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LB    = 8'h5B;
    localparam logic [7:0] CH_RB    = 8'h5D;
    localparam logic [7:0] CH_PCT   = 8'h25;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_SMALL   = 2'd2;

    localparam int OUT_TDATA_W = 184;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PREP, ST_SKIP0, ST_DECIDE, ST_TAKE, ST_NUM, ST_DIG, ST_RET,
        ST_CHK_END, ST_V6_INIT, ST_V6_TOP, ST_V6_PEEK, ST_TAIL2, ST_POST,
        ST_SH, ST_CLR, ST_BRK, ST_RES
    } state_t;

    typedef enum logic [4:0] {
        C4_OCT, C4_DOT, C4_COLON, C4_PORT, C4_BARE,
        C6_LB, C6_LC, C6_ZR, C6_W, C6_WC, C6_WD, C6_T, C6_TD,
        C6_PCT, C6_SC, C6_RB, C6_RC, C6_PORT
    } ctx_t;

    typedef enum logic [2:0] {
        TGT_COLON, TGT_DOT, TGT_LB, TGT_RB, TGT_PCT
    } tgt_t;

    typedef enum logic [1:0] {
        CUR_HOLD, CUR_INC, CUR_ZERO, CUR_START
    } cur_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_FIRST, ACC_NEXT
    } acc_op_t;

    typedef enum logic [2:0] {
        WSEL_ACC, WSEL_TAIL_HI, WSEL_TAIL_LO, WSEL_MOVE, WSEL_ZERO
    } word_sel_t;

    typedef enum logic [1:0] {
        RK_ZERO, RK_INVALID, RK_IP4, RK_IP6
    } rkind_t;

    typedef struct packed {
        logic      take_item;
        logic      len_clr;
        cur_op_t   cur_op;
        logic      start_save;
        acc_op_t   acc_op;
        logic      hex;
        logic      a4_clr;
        logic      a4_shift;
        logic      port_clr;
        logic      port_set;
        logic      scope_clr;
        logic      scope_set;
        logic      words_clr;
        logic      word_we;
        word_sel_t word_sel;
        logic [2:0] word_idx;
        logic [2:0] word_src;
        logic      oct_we;
        logic [1:0] oct_idx;
        logic      res_load;
        rkind_t    rkind;
    } dp_cmd_t;

    typedef struct packed {
        logic at_end;
        logic ws;
        logic dig_dec;
        logic dig_hex;
        logic is_colon;
        logic is_dot;
        logic is_lb;
        logic is_rb;
        logic is_pct;
        logic ovf;
        logic out_free;
    } dp_stat_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic dig_ok(input logic [7:0] c, input logic hex);
        logic dec_d;
        logic hex_d;
        dec_d = (c >= 8'h30 && c <= 8'h39);
        hex_d = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
        return dec_d || (hex && hex_d);
    endfunction

    function automatic logic [3:0] dig_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            t = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
        end
        return t[3:0];
    endfunction

    // Hex digits of the first embedded IPv4 word are read as decimal digits.
    function automatic logic [7:0] hex_as_dec(input logic [11:0] v);
        logic [11:0] t;
        t = 12'(v[3:0]) + 12'(v[7:4]) * 12'd10 + 12'(v[11:8]) * 12'd100;
        return t[7:0];
    endfunction

endpackage

// File: rtl/core/socket_address_text_parser_core.sv
// Top level of the socket address text parser: stream ports, controller and datapath.
// Loading takes one character item per cycle; tready is high while text is being collected.
// After the item marked last, the parse walks the buffer with the IPv4 grammar and, if that
// does not match, with the IPv6 grammar, then opens any zero run; one result follows.
// Reset clears the controller, length, overflow flag, address words and output valid;
// the text buffer is not cleared.
module socket_address_text_parser_core #(
    parameter int MAX_TEXT_LEN = satp_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // ch
    input  logic                             s_axis_tuser,  // has_char
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, family, addr_high, addr_low, port, scope_id, zero fill
    output logic [satp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [7:0]                       cfg_wdata
);

    satp_pkg::dp_cmd_t  cmd;
    satp_pkg::dp_stat_t stat;

    satp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .stat    (stat),
        .s_ready (s_axis_tready),
        .cmd     (cmd)
    );

    satp_dp #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (s_axis_tdata),
        .has_char  (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_axis_tvalid),
        .m_data    (m_axis_tdata)
    );

endmodule

// File: rtl/core/satp_dp.sv
// Datapath: text buffer, cursor, number accumulator, address words and result register.
module satp_dp #(
    parameter int MAX_TEXT_LEN = satp_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [7:0]                          ch,
    input  logic                                has_char,
    input  logic                                cfg_we,
    input  logic [7:0]                          cfg_wdata,
    input  logic                                m_ready,
    input  satp_pkg::dp_cmd_t                   cmd,
    output satp_pkg::dp_stat_t                  stat,
    output logic                                m_valid,
    output logic [satp_pkg::OUT_TDATA_W-1:0]    m_data
);

    localparam int AW = $clog2(MAX_TEXT_LEN);
    localparam int LW = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TEXT_LEN);

    logic [7:0]    mem [MAX_TEXT_LEN];
    logic [7:0]    char_reg;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] start_reg;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   a4_reg;
    logic [15:0]   port_reg;
    logic [31:0]   scope_reg;
    logic [15:0]   words_reg [8];
    logic [7:0]    oct_reg [3];
    logic [7:0]    cap_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic          family_reg;
    logic [63:0]   hi_reg;
    logic [63:0]   lo_reg;
    logic [15:0]   oport_reg;
    logic [31:0]   oscope_reg;
    logic [15:0]   word_wdata;
    logic [3:0]    dval;

    assign dval = satp_pkg::dig_val(char_reg);

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (cmd.len_clr)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.take_item && has_char)
        begin
            if (len_reg < LEN_MAX)
            begin
                len_next = len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cmd.cur_op)
            satp_pkg::CUR_INC:   cur_next = cur_reg + LW'(1);
            satp_pkg::CUR_ZERO:  cur_next = '0;
            satp_pkg::CUR_START: cur_next = start_reg;
            default:             cur_next = cur_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.acc_op)
            satp_pkg::ACC_FIRST: acc_next = 32'(dval);
            satp_pkg::ACC_NEXT:
            begin
                if (cmd.hex)
                begin
                    acc_next = {acc_reg[27:0], dval};
                end
                else
                begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + 32'(dval);
                end
            end
            default:             acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.word_sel)
            satp_pkg::WSEL_ACC:     word_wdata = acc_reg[15:0];
            satp_pkg::WSEL_TAIL_HI: word_wdata = {oct_reg[0], oct_reg[1]};
            satp_pkg::WSEL_TAIL_LO: word_wdata = {oct_reg[2], acc_reg[7:0]};
            satp_pkg::WSEL_MOVE:    word_wdata = words_reg[cmd.word_src];
            default:                word_wdata = 16'd0;
        endcase
    end

    // Buffer read follows the next cursor, so after loading char_reg holds the character at cur_reg.
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && has_char && (len_reg < LEN_MAX))
        begin
            mem[len_reg[AW-1:0]] <= ch;
        end
        char_reg <= mem[cur_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            cur_reg       <= '0;
            cap_reg       <= satp_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < 8; w++)
            begin
                words_reg[w] <= 16'd0;
            end
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            cur_reg <= cur_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.words_clr)
            begin
                for (int w = 0; w < 8; w++)
                begin
                    words_reg[w] <= 16'd0;
                end
            end
            else if (cmd.word_we)
            begin
                words_reg[cmd.word_idx] <= word_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.start_save)
        begin
            start_reg <= cur_reg;
        end
        if (cmd.a4_clr)
        begin
            a4_reg <= 32'd0;
        end
        else if (cmd.a4_shift)
        begin
            a4_reg <= {a4_reg[23:0], acc_reg[7:0]};
        end
        if (cmd.port_clr)
        begin
            port_reg <= 16'd0;
        end
        else if (cmd.port_set)
        begin
            port_reg <= acc_reg[15:0];
        end
        if (cmd.scope_clr)
        begin
            scope_reg <= 32'd0;
        end
        else if (cmd.scope_set)
        begin
            scope_reg <= acc_reg;
        end
        if (cmd.oct_we)
        begin
            if (cmd.oct_idx == 2'd0)
            begin
                oct_reg[0] <= satp_pkg::hex_as_dec(acc_reg[11:0]);
            end
            else
            begin
                oct_reg[cmd.oct_idx] <= acc_reg[7:0];
            end
        end
        if (cmd.res_load)
        begin
            status_reg <= satp_pkg::STATUS_OK;
            family_reg <= 1'b0;
            hi_reg     <= 64'd0;
            lo_reg     <= 64'd0;
            oport_reg  <= 16'd0;
            oscope_reg <= 32'd0;
            case (cmd.rkind)
                satp_pkg::RK_INVALID: status_reg <= satp_pkg::STATUS_INVALID;
                satp_pkg::RK_IP4:
                begin
                    if (cap_reg < satp_pkg::CAP_IP4_MIN)
                    begin
                        status_reg <= satp_pkg::STATUS_SMALL;
                    end
                    else
                    begin
                        lo_reg    <= {32'd0, a4_reg};
                        oport_reg <= port_reg;
                    end
                end
                satp_pkg::RK_IP6:
                begin
                    if (cap_reg < satp_pkg::CAP_IP6_MIN)
                    begin
                        status_reg <= satp_pkg::STATUS_SMALL;
                    end
                    else
                    begin
                        family_reg <= 1'b1;
                        hi_reg     <= {words_reg[0], words_reg[1], words_reg[2], words_reg[3]};
                        lo_reg     <= {words_reg[4], words_reg[5], words_reg[6], words_reg[7]};
                        oport_reg  <= port_reg;
                        oscope_reg <= scope_reg;
                    end
                end
                default: status_reg <= satp_pkg::STATUS_OK;
            endcase
        end
    end

    assign stat.at_end   = (cur_reg >= len_reg);
    assign stat.ws       = satp_pkg::is_ws(char_reg);
    assign stat.dig_dec  = satp_pkg::dig_ok(char_reg, 1'b0);
    assign stat.dig_hex  = satp_pkg::dig_ok(char_reg, 1'b1);
    assign stat.is_colon = (char_reg == satp_pkg::CH_COLON);
    assign stat.is_dot   = (char_reg == satp_pkg::CH_DOT);
    assign stat.is_lb    = (char_reg == satp_pkg::CH_LB);
    assign stat.is_rb    = (char_reg == satp_pkg::CH_RB);
    assign stat.is_pct   = (char_reg == satp_pkg::CH_PCT);
    assign stat.ovf      = ovf_reg;
    assign stat.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = {5'd0, oscope_reg, oport_reg, lo_reg, hi_reg, family_reg, status_reg};

endmodule

// File: rtl/core/satp_ctrl.sv
// Controller: state machine that loads the text and walks it with the IPv4 and IPv6 grammars.
module satp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  logic                s_last,
    input  satp_pkg::dp_stat_t  stat,
    output logic                s_ready,
    output satp_pkg::dp_cmd_t   cmd
);

    satp_pkg::state_t state_reg, state_next;
    satp_pkg::ctx_t   ctx_reg, ctx_next;
    satp_pkg::tgt_t   tgt_reg, tgt_next;
    satp_pkg::rkind_t rkind_reg, rkind_next;
    logic             ok_reg, ok_next;
    logic             hex_reg, hex_next;
    logic [1:0]       k_reg, k_next;
    logic [1:0]       j_reg, j_next;
    logic [3:0]       i_reg, i_next;
    logic [2:0]       zr_reg, zr_next;
    logic             hzr_reg, hzr_next;
    logic             brk_reg, brk_next;
    logic [3:0]       sj_reg, sj_next;

    logic       skip;
    logic       dig;
    logic       match;
    logic [3:0] run;
    logic [3:0] sj_dst;
    logic [3:0] sj_src;
    logic [3:0] clr_end;

    assign skip    = !stat.at_end && stat.ws;
    assign dig     = !stat.at_end && (hex_reg ? stat.dig_hex : stat.dig_dec);
    assign run     = 4'd8 - i_reg;
    assign sj_src  = sj_reg - 4'd1;
    assign sj_dst  = sj_src + run;
    assign clr_end = {1'b0, zr_reg} + run;

    always_comb
    begin
        case (tgt_reg)
            satp_pkg::TGT_COLON: match = stat.is_colon;
            satp_pkg::TGT_DOT:   match = stat.is_dot;
            satp_pkg::TGT_LB:    match = stat.is_lb;
            satp_pkg::TGT_RB:    match = stat.is_rb;
            default:             match = stat.is_pct;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= satp_pkg::ST_IDLE;
            ctx_reg   <= satp_pkg::C4_OCT;
            tgt_reg   <= satp_pkg::TGT_COLON;
            rkind_reg <= satp_pkg::RK_ZERO;
            ok_reg    <= 1'b0;
            hex_reg   <= 1'b0;
            k_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            zr_reg    <= '0;
            hzr_reg   <= 1'b0;
            brk_reg   <= 1'b0;
            sj_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            tgt_reg   <= tgt_next;
            rkind_reg <= rkind_next;
            ok_reg    <= ok_next;
            hex_reg   <= hex_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            zr_reg    <= zr_next;
            hzr_reg   <= hzr_next;
            brk_reg   <= brk_next;
            sj_reg    <= sj_next;
        end
    end

    // Next state. TAKE and NUM act as subroutines; ctx_reg says where to continue in RET.
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        tgt_next   = tgt_reg;
        rkind_next = rkind_reg;
        ok_next    = ok_reg;
        hex_next   = hex_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        zr_next    = zr_reg;
        hzr_next   = hzr_reg;
        brk_next   = brk_reg;
        sj_next    = sj_reg;
        unique case (state_reg)
            satp_pkg::ST_IDLE:
            begin
                if (s_valid && s_last)
                begin
                    state_next = satp_pkg::ST_PREP;
                end
            end
            satp_pkg::ST_PREP: state_next = satp_pkg::ST_SKIP0;
            satp_pkg::ST_SKIP0:
            begin
                if (!skip)
                begin
                    state_next = satp_pkg::ST_DECIDE;
                end
            end
            satp_pkg::ST_DECIDE:
            begin
                if (stat.ovf)
                begin
                    rkind_next = satp_pkg::RK_INVALID;
                    state_next = satp_pkg::ST_RES;
                end
                else if (stat.at_end)
                begin
                    rkind_next = satp_pkg::RK_ZERO;
                    state_next = satp_pkg::ST_RES;
                end
                else
                begin
                    k_next     = '0;
                    hex_next   = 1'b0;
                    ctx_next   = satp_pkg::C4_OCT;
                    state_next = satp_pkg::ST_NUM;
                end
            end
            satp_pkg::ST_TAKE:
            begin
                if (!skip)
                begin
                    ok_next    = !stat.at_end && match;
                    state_next = satp_pkg::ST_RET;
                end
            end
            satp_pkg::ST_NUM:
            begin
                if (!skip)
                begin
                    if (dig)
                    begin
                        state_next = satp_pkg::ST_DIG;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = satp_pkg::ST_RET;
                    end
                end
            end
            satp_pkg::ST_DIG:
            begin
                if (!dig)
                begin
                    ok_next    = 1'b1;
                    state_next = satp_pkg::ST_RET;
                end
            end
            satp_pkg::ST_CHK_END:
            begin
                if (!skip)
                begin
                    if (stat.at_end)
                    begin
                        rkind_next = satp_pkg::RK_IP4;
                        state_next = satp_pkg::ST_RES;
                    end
                    else
                    begin
                        state_next = satp_pkg::ST_V6_INIT;
                    end
                end
            end
            satp_pkg::ST_V6_INIT:
            begin
                i_next     = '0;
                hzr_next   = 1'b0;
                tgt_next   = satp_pkg::TGT_LB;
                ctx_next   = satp_pkg::C6_LB;
                state_next = satp_pkg::ST_TAKE;
            end
            satp_pkg::ST_V6_TOP:
            begin
                if (i_reg == 4'd8)
                begin
                    state_next = satp_pkg::ST_POST;
                end
                else
                begin
                    tgt_next   = satp_pkg::TGT_COLON;
                    ctx_next   = satp_pkg::C6_ZR;
                    state_next = satp_pkg::ST_TAKE;
                end
            end
            satp_pkg::ST_V6_PEEK:
            begin
                if (!skip)
                begin
                    if (stat.at_end || !stat.dig_hex)
                    begin
                        state_next = satp_pkg::ST_POST;
                    end
                    else
                    begin
                        hex_next   = 1'b1;
                        ctx_next   = satp_pkg::C6_W;
                        state_next = satp_pkg::ST_NUM;
                    end
                end
            end
            satp_pkg::ST_TAIL2:
            begin
                i_next     = i_reg + 4'd2;
                state_next = satp_pkg::ST_POST;
            end
            satp_pkg::ST_POST:
            begin
                if (hzr_reg)
                begin
                    if (({1'b0, zr_reg} < i_reg) && (i_reg != 4'd8))
                    begin
                        sj_next    = i_reg;
                        state_next = satp_pkg::ST_SH;
                    end
                    else
                    begin
                        tgt_next   = satp_pkg::TGT_PCT;
                        ctx_next   = satp_pkg::C6_PCT;
                        state_next = satp_pkg::ST_TAKE;
                    end
                end
                else if (i_reg != 4'd8)
                begin
                    rkind_next = satp_pkg::RK_INVALID;
                    state_next = satp_pkg::ST_RES;
                end
                else
                begin
                    tgt_next   = satp_pkg::TGT_PCT;
                    ctx_next   = satp_pkg::C6_PCT;
                    state_next = satp_pkg::ST_TAKE;
                end
            end
            satp_pkg::ST_SH:
            begin
                if (sj_reg > {1'b0, zr_reg})
                begin
                    sj_next = sj_src;
                end
                else
                begin
                    sj_next    = {1'b0, zr_reg};
                    state_next = satp_pkg::ST_CLR;
                end
            end
            satp_pkg::ST_CLR:
            begin
                if (sj_reg < clr_end)
                begin
                    sj_next = sj_reg + 4'd1;
                end
                else
                begin
                    tgt_next   = satp_pkg::TGT_PCT;
                    ctx_next   = satp_pkg::C6_PCT;
                    state_next = satp_pkg::ST_TAKE;
                end
            end
            satp_pkg::ST_BRK:
            begin
                if (brk_reg)
                begin
                    tgt_next   = satp_pkg::TGT_RB;
                    ctx_next   = satp_pkg::C6_RB;
                    state_next = satp_pkg::ST_TAKE;
                end
                else
                begin
                    rkind_next = satp_pkg::RK_IP6;
                    state_next = satp_pkg::ST_RES;
                end
            end
            satp_pkg::ST_RES:
            begin
                if (stat.out_free)
                begin
                    state_next = satp_pkg::ST_IDLE;
                end
            end
            satp_pkg::ST_RET:
            begin
                unique case (ctx_reg)
                    satp_pkg::C4_OCT:
                    begin
                        if (ok_reg)
                        begin
                            if (k_reg != 2'd3)
                            begin
                                tgt_next = satp_pkg::TGT_DOT;
                                ctx_next = satp_pkg::C4_DOT;
                            end
                            else
                            begin
                                tgt_next = satp_pkg::TGT_COLON;
                                ctx_next = satp_pkg::C4_COLON;
                            end
                            state_next = satp_pkg::ST_TAKE;
                        end
                        else
                        begin
                            hex_next   = 1'b0;
                            ctx_next   = satp_pkg::C4_BARE;
                            state_next = satp_pkg::ST_NUM;
                        end
                    end
                    satp_pkg::C4_DOT:
                    begin
                        hex_next   = 1'b0;
                        state_next = satp_pkg::ST_NUM;
                        if (ok_reg)
                        begin
                            k_next   = k_reg + 2'd1;
                            ctx_next = satp_pkg::C4_OCT;
                        end
                        else
                        begin
                            ctx_next = satp_pkg::C4_BARE;
                        end
                    end
                    satp_pkg::C4_COLON:
                    begin
                        if (ok_reg)
                        begin
                            hex_next   = 1'b0;
                            ctx_next   = satp_pkg::C4_PORT;
                            state_next = satp_pkg::ST_NUM;
                        end
                        else
                        begin
                            rkind_next = satp_pkg::RK_IP4;
                            state_next = satp_pkg::ST_RES;
                        end
                    end
                    satp_pkg::C4_PORT:
                    begin
                        if (ok_reg)
                        begin
                            rkind_next = satp_pkg::RK_IP4;
                            state_next = satp_pkg::ST_RES;
                        end
                        else
                        begin
                            state_next = satp_pkg::ST_V6_INIT;
                        end
                    end
                    satp_pkg::C4_BARE:
                    begin
                        state_next = ok_reg ? satp_pkg::ST_CHK_END : satp_pkg::ST_V6_INIT;
                    end
                    satp_pkg::C6_LB:
                    begin
                        brk_next   = ok_reg;
                        tgt_next   = satp_pkg::TGT_COLON;
                        ctx_next   = satp_pkg::C6_LC;
                        state_next = satp_pkg::ST_TAKE;
                    end
                    satp_pkg::C6_LC: state_next = satp_pkg::ST_V6_TOP;
                    satp_pkg::C6_ZR:
                    begin
                        if (ok_reg)
                        begin
                            hzr_next = 1'b1;
                            zr_next  = i_reg[2:0];
                        end
                        state_next = satp_pkg::ST_V6_PEEK;
                    end
                    satp_pkg::C6_W:
                    begin
                        tgt_next   = satp_pkg::TGT_COLON;
                        ctx_next   = satp_pkg::C6_WC;
                        state_next = satp_pkg::ST_TAKE;
                    end
                    satp_pkg::C6_WC:
                    begin
                        if (ok_reg)
                        begin
                            i_next     = i_reg + 4'd1;
                            state_next = satp_pkg::ST_V6_TOP;
                        end
                        else
                        begin
                            tgt_next   = satp_pkg::TGT_DOT;
                            ctx_next   = satp_pkg::C6_WD;
                            state_next = satp_pkg::ST_TAKE;
                        end
                    end
                    satp_pkg::C6_WD:
                    begin
                        if (ok_reg)
                        begin
                            if (i_reg > 4'd6)
                            begin
                                rkind_next = satp_pkg::RK_INVALID;
                                state_next = satp_pkg::ST_RES;
                            end
                            else
                            begin
                                j_next     = 2'd1;
                                hex_next   = 1'b0;
                                ctx_next   = satp_pkg::C6_T;
                                state_next = satp_pkg::ST_NUM;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + 4'd1;
                            state_next = satp_pkg::ST_POST;
                        end
                    end
                    satp_pkg::C6_T:
                    begin
                        if (!ok_reg)
                        begin
                            rkind_next = satp_pkg::RK_INVALID;
                            state_next = satp_pkg::ST_RES;
                        end
                        else if (j_reg != 2'd3)
                        begin
                            tgt_next   = satp_pkg::TGT_DOT;
                            ctx_next   = satp_pkg::C6_TD;
                            state_next = satp_pkg::ST_TAKE;
                        end
                        else
                        begin
                            state_next = satp_pkg::ST_TAIL2;
                        end
                    end
                    satp_pkg::C6_TD:
                    begin
                        if (ok_reg)
                        begin
                            j_next     = j_reg + 2'd1;
                            hex_next   = 1'b0;
                            ctx_next   = satp_pkg::C6_T;
                            state_next = satp_pkg::ST_NUM;
                        end
                        else
                        begin
                            rkind_next = satp_pkg::RK_INVALID;
                            state_next = satp_pkg::ST_RES;
                        end
                    end
                    satp_pkg::C6_PCT:
                    begin
                        if (ok_reg)
                        begin
                            hex_next   = 1'b0;
                            ctx_next   = satp_pkg::C6_SC;
                            state_next = satp_pkg::ST_NUM;
                        end
                        else
                        begin
                            state_next = satp_pkg::ST_BRK;
                        end
                    end
                    satp_pkg::C6_SC:
                    begin
                        if (ok_reg)
                        begin
                            state_next = satp_pkg::ST_BRK;
                        end
                        else
                        begin
                            rkind_next = satp_pkg::RK_INVALID;
                            state_next = satp_pkg::ST_RES;
                        end
                    end
                    satp_pkg::C6_RB:
                    begin
                        if (ok_reg)
                        begin
                            tgt_next   = satp_pkg::TGT_COLON;
                            ctx_next   = satp_pkg::C6_RC;
                            state_next = satp_pkg::ST_TAKE;
                        end
                        else
                        begin
                            rkind_next = satp_pkg::RK_INVALID;
                            state_next = satp_pkg::ST_RES;
                        end
                    end
                    satp_pkg::C6_RC:
                    begin
                        if (ok_reg)
                        begin
                            hex_next   = 1'b0;
                            ctx_next   = satp_pkg::C6_PORT;
                            state_next = satp_pkg::ST_NUM;
                        end
                        else
                        begin
                            rkind_next = satp_pkg::RK_IP6;
                            state_next = satp_pkg::ST_RES;
                        end
                    end
                    satp_pkg::C6_PORT:
                    begin
                        rkind_next = ok_reg ? satp_pkg::RK_IP6 : satp_pkg::RK_INVALID;
                        state_next = satp_pkg::ST_RES;
                    end
                    default: state_next = satp_pkg::ST_IDLE;
                endcase
            end
            default: state_next = satp_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd          = '0;
        cmd.cur_op   = satp_pkg::CUR_HOLD;
        cmd.acc_op   = satp_pkg::ACC_HOLD;
        cmd.word_sel = satp_pkg::WSEL_ACC;
        cmd.rkind    = rkind_reg;
        cmd.hex      = hex_reg;
        cmd.word_idx = i_reg[2:0];
        s_ready      = 1'b0;
        unique case (state_reg)
            satp_pkg::ST_IDLE:
            begin
                s_ready       = 1'b1;
                cmd.take_item = s_valid;
            end
            satp_pkg::ST_SKIP0:
            begin
                if (skip)
                begin
                    cmd.cur_op = satp_pkg::CUR_INC;
                end
                else
                begin
                    cmd.start_save = 1'b1;
                end
            end
            satp_pkg::ST_DECIDE:
            begin
                cmd.a4_clr   = 1'b1;
                cmd.port_clr = 1'b1;
            end
            satp_pkg::ST_TAKE:
            begin
                if (skip || (!stat.at_end && match))
                begin
                    cmd.cur_op = satp_pkg::CUR_INC;
                end
            end
            satp_pkg::ST_NUM:
            begin
                if (skip)
                begin
                    cmd.cur_op = satp_pkg::CUR_INC;
                end
                else if (dig)
                begin
                    cmd.cur_op = satp_pkg::CUR_INC;
                    cmd.acc_op = satp_pkg::ACC_FIRST;
                end
            end
            satp_pkg::ST_DIG:
            begin
                if (dig)
                begin
                    cmd.cur_op = satp_pkg::CUR_INC;
                    cmd.acc_op = satp_pkg::ACC_NEXT;
                end
            end
            satp_pkg::ST_CHK_END, satp_pkg::ST_V6_PEEK:
            begin
                if (skip)
                begin
                    cmd.cur_op = satp_pkg::CUR_INC;
                end
            end
            satp_pkg::ST_V6_INIT:
            begin
                cmd.cur_op    = satp_pkg::CUR_START;
                cmd.words_clr = 1'b1;
                cmd.port_clr  = 1'b1;
                cmd.scope_clr = 1'b1;
            end
            satp_pkg::ST_TAIL2:
            begin
                cmd.word_we  = 1'b1;
                cmd.word_sel = satp_pkg::WSEL_TAIL_LO;
                cmd.word_idx = i_reg[2:0] + 3'd1;
            end
            satp_pkg::ST_SH:
            begin
                cmd.word_we  = (sj_reg > {1'b0, zr_reg});
                cmd.word_sel = satp_pkg::WSEL_MOVE;
                cmd.word_idx = sj_dst[2:0];
                cmd.word_src = sj_src[2:0];
            end
            satp_pkg::ST_CLR:
            begin
                cmd.word_we  = (sj_reg < clr_end);
                cmd.word_sel = satp_pkg::WSEL_ZERO;
                cmd.word_idx = sj_reg[2:0];
            end
            satp_pkg::ST_RES:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.len_clr  = 1'b1;
                    cmd.cur_op   = satp_pkg::CUR_ZERO;
                end
            end
            satp_pkg::ST_RET:
            begin
                case (ctx_reg)
                    satp_pkg::C4_OCT:
                    begin
                        cmd.a4_shift = ok_reg;
                        if (!ok_reg)
                        begin
                            cmd.cur_op = satp_pkg::CUR_START;
                        end
                    end
                    satp_pkg::C4_DOT:
                    begin
                        if (!ok_reg)
                        begin
                            cmd.cur_op = satp_pkg::CUR_START;
                        end
                    end
                    satp_pkg::C4_PORT, satp_pkg::C6_PORT: cmd.port_set = ok_reg;
                    satp_pkg::C4_BARE:
                    begin
                        cmd.port_set = ok_reg;
                        cmd.a4_clr   = ok_reg;
                    end
                    satp_pkg::C6_WC: cmd.word_we = ok_reg;
                    satp_pkg::C6_WD:
                    begin
                        cmd.word_we = !ok_reg;
                        cmd.oct_we  = ok_reg && (i_reg <= 4'd6);
                        cmd.oct_idx = 2'd0;
                    end
                    satp_pkg::C6_T:
                    begin
                        if (ok_reg && (j_reg != 2'd3))
                        begin
                            cmd.oct_we  = 1'b1;
                            cmd.oct_idx = j_reg;
                        end
                        else if (ok_reg)
                        begin
                            cmd.word_we  = 1'b1;
                            cmd.word_sel = satp_pkg::WSEL_TAIL_HI;
                        end
                    end
                    satp_pkg::C6_SC: cmd.scope_set = ok_reg;
                    default: cmd.cur_op = satp_pkg::CUR_HOLD;
                endcase
            end
            default: cmd.cur_op = satp_pkg::CUR_HOLD;
        endcase
    end

endmodule

// File: rtl/core/satp_chk.sv
// Port checker of the socket address text parser, bound to the top level.
module satp_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [satp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // A failed parse reports nothing but its status.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != satp_pkg::STATUS_OK)
        |-> m_axis_tdata[satp_pkg::OUT_TDATA_W-1:2] == '0)
        else $error("failed result carries data");

    // IPv4 results use only the low half of addr_low and the port.
    a_ip4_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2]
        |-> m_axis_tdata[66:3] == '0 && m_axis_tdata[130:99] == '0 &&
            m_axis_tdata[178:147] == '0)
        else $error("IPv4 result with IPv6 fields set");

endmodule

bind socket_address_text_parser_core satp_chk u_satp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
